### rtl/core/gpl_pkg.sv
// Shared types and constants of the GPIO port with configuration lock.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gpl_pkg;

    // Number of pins the port is built for, and the widths of the bus fields.
    localparam int unsigned GPL_PIN_COUNT  = 16;
    localparam int unsigned GPL_PIN_W      = 16;
    localparam int unsigned GPL_WORD_W     = 32;
    localparam int unsigned GPL_PINS_WORD  = 8;

    // Reset value of both mode words, and of the nibble of an absent pin.
    localparam logic [GPL_WORD_W-1:0] GPL_MODE_RESET = 32'h4444_4444;

    // Bit of a lock word that carries the key.
    localparam int unsigned GPL_KEY_BIT = 16;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_MODE_LOW  = 3'd0,
        REG_MODE_HIGH = 3'd1,
        REG_INPUT     = 3'd2,
        REG_OUTPUT    = 3'd3,
        REG_SET       = 3'd4,
        REG_RESET     = 3'd5,
        REG_LOCK      = 3'd6
    } t_reg_sel;

    // Progress through the lock key sequence.
    typedef enum logic [1:0] {
        KEY_IDLE   = 2'd0,
        KEY_FIRST  = 2'd1,
        KEY_SECOND = 2'd2,
        KEY_ARMED  = 2'd3
    } t_key_phase;

    // One bus access as it sits in the input register.
    typedef struct packed {
        t_op                   op;
        t_reg_sel              sel;
        logic [GPL_WORD_W-1:0] data;
        logic [GPL_PIN_W-1:0]  levels;
    } t_access;

    // Port state seen by the outside.
    typedef struct packed {
        logic [GPL_PIN_W-1:0]  pin_drive;
        logic [GPL_WORD_W-1:0] mode_low;
        logic [GPL_WORD_W-1:0] mode_high;
        logic                  lock_active;
    } t_port_view;

endpackage

`default_nettype wire

### rtl/core/gpl_core.sv
// Register file of the GPIO port: mode words, output data, lock bits and the
// lock key sequencer, with the read mux. Depends on gpl_pkg.
`default_nettype none

module gpl_core #(
    parameter int unsigned PIN_COUNT = gpl_pkg::GPL_PIN_COUNT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gpl_pkg::t_access                i_access,
    input  wire logic                            i_commit,
    output logic [gpl_pkg::GPL_WORD_W-1:0]       o_read_data,
    output gpl_pkg::t_port_view                  o_view
);
    import gpl_pkg::*;

    localparam logic [GPL_PIN_W-1:0] PinMask =
        GPL_PIN_W'((33'd1 << PIN_COUNT) - 33'd1);

    logic [GPL_WORD_W-1:0] r_mode_low,  n_mode_low;
    logic [GPL_WORD_W-1:0] r_mode_high, n_mode_high;
    logic [GPL_PIN_W-1:0]  r_out_data,  n_out_data;
    logic [GPL_PIN_W-1:0]  r_lock_bits, n_lock_bits;
    logic                  r_lock_key,  n_lock_key;
    t_key_phase            r_phase,     n_phase;
    logic [GPL_PIN_W-1:0]  r_pattern,   n_pattern;

    logic [GPL_WORD_W-1:0] w_mask_low;
    logic [GPL_WORD_W-1:0] w_mask_high;
    logic [GPL_PIN_W-1:0]  w_pat;
    logic                  w_key;
    logic                  w_match;

    // A nibble is writable when its pin exists and is not frozen by the lock.
    always_comb begin
        for (int i = 0; i < GPL_PINS_WORD; i++) begin
            w_mask_low[4*i +: 4]  = {4{(i < PIN_COUNT) && !(r_lock_key && r_lock_bits[i])}};
            w_mask_high[4*i +: 4] = {4{((i + GPL_PINS_WORD) < PIN_COUNT)
                                       && !(r_lock_key && r_lock_bits[i + GPL_PINS_WORD])}};
        end
    end

    assign w_pat   = i_access.data[GPL_PIN_W-1:0];
    assign w_key   = i_access.data[GPL_KEY_BIT];
    assign w_match = (w_pat == r_pattern);

    always_comb begin
        n_mode_low  = r_mode_low;
        n_mode_high = r_mode_high;
        n_out_data  = r_out_data;
        n_lock_bits = r_lock_bits;
        n_lock_key  = r_lock_key;
        n_phase     = r_phase;
        n_pattern   = r_pattern;
        o_read_data = '0;
        if (i_access.op == OP_WRITE) begin
            case (i_access.sel)
                REG_MODE_LOW: begin
                    n_mode_low = (r_mode_low & ~w_mask_low) | (i_access.data & w_mask_low);
                end
                REG_MODE_HIGH: begin
                    n_mode_high = (r_mode_high & ~w_mask_high)
                                | (i_access.data & w_mask_high);
                end
                REG_OUTPUT: begin
                    n_out_data = w_pat & PinMask;
                end
                REG_SET: begin
                    n_out_data = (r_out_data | w_pat) & PinMask;
                end
                REG_RESET: begin
                    n_out_data = r_out_data & ~w_pat & PinMask;
                end
                REG_LOCK: begin
                    if (!r_lock_key) begin
                        // A write that is not the expected step restarts the
                        // sequence, and starts a new one if it carries the key.
                        if (r_phase == KEY_FIRST && !w_key && w_match) begin
                            n_phase = KEY_SECOND;
                        end else if (r_phase == KEY_SECOND && w_key && w_match) begin
                            n_phase = KEY_ARMED;
                        end else if (w_key) begin
                            n_phase   = KEY_FIRST;
                            n_pattern = w_pat;
                        end else begin
                            n_phase = KEY_IDLE;
                        end
                        n_lock_bits = w_pat & PinMask;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_access.sel)
                REG_MODE_LOW:  o_read_data = r_mode_low;
                REG_MODE_HIGH: o_read_data = r_mode_high;
                REG_INPUT:     o_read_data = GPL_WORD_W'(i_access.levels & PinMask);
                REG_OUTPUT:    o_read_data = GPL_WORD_W'(r_out_data);
                REG_LOCK: begin
                    // The closing read still returns the key bit as zero.
                    o_read_data = GPL_WORD_W'({r_lock_key, r_lock_bits});
                    if (!r_lock_key) begin
                        if (r_phase == KEY_ARMED) begin
                            n_lock_key = 1'b1;
                        end
                        n_phase = KEY_IDLE;
                    end
                end
                default: o_read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_low  <= GPL_MODE_RESET;
            r_mode_high <= GPL_MODE_RESET;
            r_out_data  <= '0;
            r_lock_bits <= '0;
            r_lock_key  <= 1'b0;
            r_phase     <= KEY_IDLE;
            r_pattern   <= '0;
        end else if (i_commit) begin
            r_mode_low  <= n_mode_low;
            r_mode_high <= n_mode_high;
            r_out_data  <= n_out_data;
            r_lock_bits <= n_lock_bits;
            r_lock_key  <= n_lock_key;
            r_phase     <= n_phase;
            r_pattern   <= n_pattern;
        end
    end

    assign o_view.pin_drive   = r_out_data;
    assign o_view.mode_low    = r_mode_low;
    assign o_view.mode_high   = r_mode_high;
    assign o_view.lock_active = r_lock_key;

endmodule

`default_nettype wire

### rtl/core/gpio_port_with_lock.sv
// Top level of the GPIO port with configuration lock: input register, result
// register and handshake control around gpl_core. Depends on gpl_pkg, gpl_core.
//
//   Channel   Direction  Handshake               Payload
//   access    in         i_in_valid / o_in_stall i_op, i_reg_select, i_write_data,
//                                                i_pin_levels
//   result    out        o_out_valid / i_out_stall o_read_data, o_pin_drive,
//                                                o_mode_low_word, o_mode_high_word,
//                                                o_lock_active
//
// The port takes one access beat per cycle while o_in_stall is low. An
// accepted beat sits in the input register until it moves on; then the
// register file updates and the read data is captured in the result register.
// Reset is synchronous and active low; it empties both registers and restores
// the port state. A stalled result holds both its read data and the port state
// behind it; an access beat then waits in the input register and the access
// side is stalled only while that register is full.
`default_nettype none

module gpio_port_with_lock #(
    parameter int unsigned PIN_COUNT = gpl_pkg::GPL_PIN_COUNT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic [2:0]                        i_reg_select,
    input  wire logic [gpl_pkg::GPL_WORD_W-1:0]    i_write_data,
    input  wire logic [gpl_pkg::GPL_PIN_W-1:0]     i_pin_levels,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [gpl_pkg::GPL_WORD_W-1:0]         o_read_data,
    output logic [gpl_pkg::GPL_PIN_W-1:0]          o_pin_drive,
    output logic [gpl_pkg::GPL_WORD_W-1:0]         o_mode_low_word,
    output logic [gpl_pkg::GPL_WORD_W-1:0]         o_mode_high_word,
    output logic                                   o_lock_active
);
    import gpl_pkg::*;

    logic                  r_in_valid,  n_in_valid;
    t_access               r_in;
    logic                  r_out_valid, n_out_valid;
    logic [GPL_WORD_W-1:0] r_read_data;

    logic                  w_in_accept;
    logic                  w_advance;
    logic [GPL_WORD_W-1:0] w_read_data;
    t_port_view            w_view;

    // The held access moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.op     <= t_op'(i_op);
            r_in.sel    <= t_reg_sel'(i_reg_select);
            r_in.data   <= i_write_data;
            r_in.levels <= i_pin_levels;
        end
        if (w_advance) begin
            r_read_data <= w_read_data;
        end
    end

    gpl_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_access    (r_in),
        .i_commit    (w_advance),
        .o_read_data (w_read_data),
        .o_view      (w_view)
    );

    // The port state changes only on the edge that loads a new result, so it
    // stays in step with the result register.
    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_pin_drive      = w_view.pin_drive;
    assign o_mode_low_word  = w_view.mode_low;
    assign o_mode_high_word = w_view.mode_high;
    assign o_lock_active    = w_view.lock_active;

endmodule

`default_nettype wire

### rtl/core/gpl_chk.sv
// Port-level checks of the GPIO port with configuration lock, and the bind
// that attaches them to gpio_port_with_lock. Depends on gpl_pkg.
`default_nettype none

module gpl_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [gpl_pkg::GPL_WORD_W-1:0]    o_read_data,
    input wire logic [gpl_pkg::GPL_PIN_W-1:0]     o_pin_drive,
    input wire logic                              o_lock_active
);
    import gpl_pkg::*;

    // A stalled result beat holds its read data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("result beat changed while stalled");

    // Once armed, the lock stays armed until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_lock_active |=> o_lock_active)
        else $error("lock released without reset");

    // The lock arms only with the closing lock read, which shows the key as zero.
    a_lock_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_lock_active) |->
            o_out_valid && !o_read_data[GPL_KEY_BIT])
        else $error("lock armed without its closing read");

    // Pin drive moves only together with a fresh result beat.
    a_drive_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_pin_drive) |-> o_out_valid)
        else $error("pin drive changed without a result beat");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind gpio_port_with_lock gpl_chk u_gpl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_data   (o_read_data),
    .o_pin_drive   (o_pin_drive),
    .o_lock_active (o_lock_active)
);

`default_nettype wire
